// ===== rtl/gpio_port_register_bank_macros.svh =====
// Assertion macros for the GPIO port register bank.
`ifndef GPIO_PORT_REGISTER_BANK_MACROS_SVH
`define GPIO_PORT_REGISTER_BANK_MACROS_SVH

`ifndef SYNTH
`define GPB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define GPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define GPB_ASSERT(lbl, clk, rst_n, prop)
`define GPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gpb_pkg.sv =====
package gpb_pkg;

  localparam int unsigned PORT_WIDTH       = 16;
  localparam int unsigned NUM_PINS_DEFAULT = 16;
  localparam int unsigned DATA_WIDTH       = 32;
  localparam int unsigned OFS_WIDTH        = 8;

  typedef logic [OFS_WIDTH-1:0] offset_t;

  localparam offset_t OFS_MODE     = 8'd0;
  localparam offset_t OFS_TYPE     = 8'd1;
  localparam offset_t OFS_SPEED    = 8'd2;
  localparam offset_t OFS_PULL     = 8'd3;
  localparam offset_t OFS_IN       = 8'd4;
  localparam offset_t OFS_OUT      = 8'd5;
  localparam offset_t OFS_SETRESET = 8'd6;
  localparam offset_t OFS_LOCK     = 8'd7;
  localparam offset_t OFS_AFLO     = 8'd8;
  localparam offset_t OFS_AFHI     = 8'd9;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [1:0] MODE_OUTPUT = 2'b01;

  typedef struct packed {
    logic                  func;
    offset_t               word_offset;
    logic [DATA_WIDTH-1:0] write_data;
  } access_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  bad_offset;
    logic [PORT_WIDTH-1:0] pin_levels;
  } result_t;

  // Access handed from the input register to the register file.
  typedef struct packed {
    logic    commit;
    access_t access;
  } exec_t;

  // A pin drives only when its two mode bits select general output.
  function automatic logic [PORT_WIDTH-1:0] derive_mask(input logic [DATA_WIDTH-1:0] mode,
                                                        input int unsigned num_pins);
    logic [PORT_WIDTH-1:0] m;
    m = '0;
    for (int unsigned p = 0; p < PORT_WIDTH; p++) begin
      m[p] = (p < num_pins) && (mode[2*p +: 2] == MODE_OUTPUT);
    end
    return m;
  endfunction

endpackage

// ===== rtl/gpb_if.sv =====
interface gpb_access_if;
  import gpb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [OFS_WIDTH-1:0]  word_offset;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, output func, output word_offset, output write_data,
                  input ready);
  modport sink   (input valid, input func, input word_offset, input write_data,
                  output ready);
endinterface

interface gpb_result_if;
  import gpb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  bad_offset;
  logic [PORT_WIDTH-1:0] pin_levels;

  modport source (output valid, output read_data, output bad_offset, output pin_levels,
                  input ready);
  modport sink   (input valid, input read_data, input bad_offset, input pin_levels,
                  output ready);
endinterface

// ===== rtl/gpb_in_stage.sv =====
module gpb_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  gpb_pkg::access_t access_i,
  output logic             ready_o,
  input  logic             take_i,
  output logic             valid_o,
  output gpb_pkg::access_t access_o
);
  import gpb_pkg::*;

  logic    valid_q;
  access_t access_q;

  // The register frees up in the same cycle as its beat moves on.
  assign ready_o  = !valid_q || take_i;
  assign valid_o  = valid_q;
  assign access_o = access_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      access_q <= access_i;
    end
  end

endmodule

// ===== rtl/gpb_regfile.sv =====
module gpb_regfile #(
  parameter int unsigned NUM_PINS = gpb_pkg::NUM_PINS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gpb_pkg::exec_t   exec_i,
  output gpb_pkg::result_t result_o
);
  import gpb_pkg::*;

  logic [DATA_WIDTH-1:0] mode_q, type_q, speed_q, pull_q, lock_q;
  logic [DATA_WIDTH-1:0] alt_q [2];
  logic [PORT_WIDTH-1:0] in_q, in_d, out_q, out_d, mask_q;

  access_t               acc;
  logic                  bad;
  logic                  is_wr;
  logic                  wr_en;
  logic [PORT_WIDTH-1:0] clr, set, clr_m, set_m;
  logic [DATA_WIDTH-1:0] rd;

  assign acc   = exec_i.access;
  assign bad   = acc.word_offset > OFS_AFHI;
  assign is_wr = (acc.func == FUNC_WRITE) && !bad;
  assign wr_en = exec_i.commit && is_wr;

  always_comb begin
    clr = '0;
    set = '0;
    if (is_wr) begin
      unique case (acc.word_offset)
        OFS_OUT: begin
          clr = '1;
          set = acc.write_data[PORT_WIDTH-1:0];
        end
        OFS_SETRESET: begin
          clr = acc.write_data[2*PORT_WIDTH-1:PORT_WIDTH];
          set = acc.write_data[PORT_WIDTH-1:0];
        end
        default: begin
          clr = '0;
          set = '0;
        end
      endcase
    end
  end

  // Set is applied after clear, so a pin named in both halves ends up high.
  assign clr_m = clr & mask_q;
  assign set_m = set & mask_q;
  assign out_d = (out_q & ~clr_m) | set_m;
  assign in_d  = (in_q & ~clr_m) | set_m;

  always_comb begin
    rd = '0;
    if (acc.func == FUNC_READ) begin
      unique case (acc.word_offset)
        OFS_MODE:  rd = mode_q;
        OFS_TYPE:  rd = type_q;
        OFS_SPEED: rd = speed_q;
        OFS_PULL:  rd = pull_q;
        OFS_IN:    rd = {{(DATA_WIDTH-PORT_WIDTH){1'b0}}, in_q};
        OFS_OUT:   rd = {{(DATA_WIDTH-PORT_WIDTH){1'b0}}, out_q};
        OFS_LOCK:  rd = lock_q;
        OFS_AFLO:  rd = alt_q[0];
        OFS_AFHI:  rd = alt_q[1];
        default:   rd = '0;
      endcase
    end
  end

  assign result_o.read_data  = rd;
  assign result_o.bad_offset = bad;
  assign result_o.pin_levels = out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      type_q   <= '0;
      speed_q  <= '0;
      pull_q   <= '0;
      lock_q   <= '0;
      alt_q[0] <= '0;
      alt_q[1] <= '0;
      in_q     <= '0;
      out_q    <= '0;
      mask_q   <= '0;
    end else if (wr_en) begin
      in_q  <= in_d;
      out_q <= out_d;
      unique case (acc.word_offset)
        OFS_MODE: begin
          mode_q <= acc.write_data;
          mask_q <= derive_mask(acc.write_data, NUM_PINS);
        end
        OFS_TYPE:  type_q   <= acc.write_data;
        OFS_SPEED: speed_q  <= acc.write_data;
        OFS_PULL:  pull_q   <= acc.write_data;
        OFS_LOCK:  lock_q   <= acc.write_data;
        OFS_AFLO:  alt_q[0] <= acc.write_data;
        OFS_AFHI:  alt_q[1] <= acc.write_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/gpb_out_stage.sv =====
module gpb_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  gpb_pkg::result_t result_i,
  output logic             ready_o,
  output logic             valid_o,
  output gpb_pkg::result_t result_o,
  input  logic             ready_i
);
  import gpb_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== rtl/gpio_port_register_bank.sv =====
// Register bank of a general-purpose I/O port with up to sixteen pins.
// Bus accesses arrive on acc_i: func selects read or write, word_offset names the
// register and write_data carries the value of a write. Every access returns one
// beat on res_o with the read data, a bad-offset flag and the output data now
// driven to the pins.
// A beat is captured in an input register, executed against the register file
// once the result register can take it and held in the result register, from
// which its result is offered on res_o. One access is accepted in every cycle
// while res_o is taken; accesses complete strictly in order.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more access; acc_i.ready then drops until res_o
// moves again.
// Reset clears every register of the register file, so all pins are inputs and
// drive nothing, and empties both the input and the result register.
`include "gpio_port_register_bank_macros.svh"

module gpio_port_register_bank #(
  parameter int unsigned NUM_PINS = gpb_pkg::NUM_PINS_DEFAULT
) (
  input logic          clk_i,
  input logic          rst_ni,
  gpb_access_if.sink   acc_i,
  gpb_result_if.source res_o
);
  import gpb_pkg::*;

  localparam logic [PORT_WIDTH-1:0] PinMask =
    PORT_WIDTH'((32'd1 << NUM_PINS) - 32'd1);

  access_t in_access, s1_access;
  logic    s1_valid;
  logic    out_ready;
  logic    advance;
  exec_t   exec;
  result_t exec_result, res;

  assign in_access.func        = acc_i.func;
  assign in_access.word_offset = acc_i.word_offset;
  assign in_access.write_data  = acc_i.write_data;

  assign advance     = s1_valid && out_ready;
  assign exec.commit = advance;
  assign exec.access = s1_access;

  gpb_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (acc_i.valid),
    .access_i (in_access),
    .ready_o  (acc_i.ready),
    .take_i   (advance),
    .valid_o  (s1_valid),
    .access_o (s1_access)
  );

  gpb_regfile #(
    .NUM_PINS (NUM_PINS)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .result_o (exec_result)
  );

  gpb_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .result_i (exec_result),
    .ready_o  (out_ready),
    .valid_o  (res_o.valid),
    .result_o (res),
    .ready_i  (res_o.ready)
  );

  assign res_o.read_data  = res.read_data;
  assign res_o.bad_offset = res.bad_offset;
  assign res_o.pin_levels = res.pin_levels;

  // The bank only refuses an access while both stages hold a beat.
  `GPB_ASSERT_IMPL(a_ready_only_on_stall, clk_i, rst_ni, !acc_i.ready,
                   res_o.valid && !res_o.ready && s1_valid)
  `GPB_ASSERT_IMPL(a_bad_reads_zero, clk_i, rst_ni, res_o.valid && res_o.bad_offset,
                   res_o.read_data == '0)
  `GPB_ASSERT_IMPL(a_no_unbuilt_pins, clk_i, rst_ni, res_o.valid,
                   (res_o.pin_levels & ~PinMask) == '0)

endmodule

// ===== verif/gpio_port_register_bank_tb.sv =====
module gpio_port_register_bank_tb;
  import gpb_pkg::*;

  localparam int unsigned NUM_PINS      = NUM_PINS_DEFAULT;
  localparam int unsigned PHASE_ITEMS   = 440;
  localparam int unsigned NUM_PHASES    = 4;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 10;

  // Shadow copy of the register bank and the queue of results it predicts.
  class gpio_bank_scoreboard;
    logic [DATA_WIDTH-1:0] mode_q, out_type_q, speed_q, pull_q, lock_q;
    logic [DATA_WIDTH-1:0] alt_func_q [2];
    logic [PORT_WIDTH-1:0] in_data_q, out_data_q, drive_mask_q;
    result_t               pending_q [$];
    int unsigned           errors, n_reads, n_writes, n_unmapped, n_results;

    function new();
      mode_q = '0; out_type_q = '0; speed_q = '0; pull_q = '0; lock_q = '0;
      alt_func_q[0] = '0; alt_func_q[1] = '0;
      in_data_q = '0; out_data_q = '0; drive_mask_q = '0;
      errors = 0; n_reads = 0; n_writes = 0; n_unmapped = 0; n_results = 0;
    endfunction

    // A pin drives only when its mode field selects general output.
    function logic [PORT_WIDTH-1:0] output_pins(logic [DATA_WIDTH-1:0] mode);
      logic [PORT_WIDTH-1:0] m;
      m = '0;
      for (int unsigned p = 0; p < PORT_WIDTH; p++)
        if (p < NUM_PINS && mode[2*p +: 2] == MODE_OUTPUT) m[p] = 1'b1;
      return m;
    endfunction

    function void drive_pins(logic [PORT_WIDTH-1:0] clr, logic [PORT_WIDTH-1:0] set);
      logic [PORT_WIDTH-1:0] c, s;
      c = clr & drive_mask_q;
      s = set & drive_mask_q;
      out_data_q = (out_data_q & ~c) | s;
      in_data_q  = (in_data_q & ~c) | s;
    endfunction

    function void note_access(logic f, offset_t ofs, logic [DATA_WIDTH-1:0] wd);
      result_t r;
      r = '0;
      if (ofs > OFS_AFHI) begin
        r.bad_offset = 1'b1;
        n_unmapped++;
      end else if (f == FUNC_WRITE) begin
        n_writes++;
        case (ofs)
          OFS_MODE: begin
            mode_q       = wd;
            drive_mask_q = output_pins(wd);
          end
          OFS_TYPE:     out_type_q = wd;
          OFS_SPEED:    speed_q = wd;
          OFS_PULL:     pull_q = wd;
          OFS_OUT:      drive_pins('1, wd[15:0]);
          OFS_SETRESET: drive_pins(wd[31:16], wd[15:0]);
          OFS_LOCK:     lock_q = wd;
          OFS_AFLO:     alt_func_q[0] = wd;
          OFS_AFHI:     alt_func_q[1] = wd;
          default: ;
        endcase
      end else begin
        n_reads++;
        case (ofs)
          OFS_MODE:  r.read_data = mode_q;
          OFS_TYPE:  r.read_data = out_type_q;
          OFS_SPEED: r.read_data = speed_q;
          OFS_PULL:  r.read_data = pull_q;
          OFS_IN:    r.read_data = {16'h0, in_data_q};
          OFS_OUT:   r.read_data = {16'h0, out_data_q};
          OFS_LOCK:  r.read_data = lock_q;
          OFS_AFLO:  r.read_data = alt_func_q[0];
          OFS_AFHI:  r.read_data = alt_func_q[1];
          default:   r.read_data = '0;
        endcase
      end
      r.pin_levels = out_data_q;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [DATA_WIDTH-1:0] rd, logic bad, logic [PORT_WIDTH-1:0] pins);
      result_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (read_data %h)", $time, rd);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (rd !== e.read_data) begin
        $display("%0t: read_data expected %h, got %h", $time, e.read_data, rd);
        errors++;
      end
      if (bad !== e.bad_offset) begin
        $display("%0t: bad_offset expected %b, got %b", $time, e.bad_offset, bad);
        errors++;
      end
      if (pins !== e.pin_levels) begin
        $display("%0t: pin_levels expected %h, got %h", $time, e.pin_levels, pins);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic src_idle_on;
  logic snk_idle_on;
  int unsigned quiet_cycles;

  gpb_access_if acc_bus ();
  gpb_result_if res_bus ();

  gpio_bank_scoreboard sb = new();

  gpio_port_register_bank #(.NUM_PINS(NUM_PINS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc_bus),
    .res_o  (res_bus)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && acc_bus.valid && acc_bus.ready)
      sb.note_access(acc_bus.func, acc_bus.word_offset, acc_bus.write_data);
    if (rst_ni && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.read_data, res_bus.bad_offset, res_bus.pin_levels);
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((acc_bus.valid && acc_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stalls in random bursts while stalling is enabled.
  initial begin
    forever begin
      @(negedge clk_i);
      if (snk_idle_on && $urandom_range(0, 3) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_access(input logic f, input offset_t ofs, input logic [DATA_WIDTH-1:0] wd);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      acc_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    acc_bus.valid       <= 1'b1;
    acc_bus.func        <= f;
    acc_bus.word_offset <= ofs;
    acc_bus.write_data  <= wd;
    do @(posedge clk_i); while (!acc_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    acc_bus.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Each pin is an output at least half the time so writes have pins to drive.
  function automatic logic [DATA_WIDTH-1:0] random_mode();
    logic [DATA_WIDTH-1:0] m;
    m = '0;
    for (int p = 0; p < PORT_WIDTH; p++)
      m[2*p +: 2] = $urandom_range(0, 1) ? MODE_OUTPUT : 2'($urandom_range(0, 3));
    return m;
  endfunction

  task automatic send_random_access();
    logic                  f;
    offset_t               ofs;
    logic [DATA_WIDTH-1:0] wd;
    f  = 1'($urandom_range(0, 1));
    wd = $urandom;
    if ($urandom_range(0, 99) < 8)
      ofs = offset_t'($urandom_range(OFS_AFHI + 1, 255));
    else
      ofs = offset_t'($urandom_range(OFS_MODE, OFS_AFHI));
    if (f == FUNC_WRITE && ofs == OFS_MODE && $urandom_range(0, 3) != 0)
      wd = random_mode();
    send_access(f, ofs, wd);
  endtask

  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    src_idle_on         = 1'b0;
    snk_idle_on         = 1'b0;
    quiet_cycles        = 0;
    acc_bus.valid       = 1'b0;
    acc_bus.func        = FUNC_READ;
    acc_bus.word_offset = OFS_MODE;
    acc_bus.write_data  = '0;
    res_bus.ready       = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset values, unmapped offsets, masking and the set/reset port.
    send_access(FUNC_READ,  OFS_MODE,     '0);
    send_access(FUNC_READ,  8'd255,       '0);
    send_access(FUNC_WRITE, 8'd10,        32'hFFFF_FFFF);
    send_access(FUNC_WRITE, OFS_MODE,     32'h5555_5555);
    send_access(FUNC_WRITE, OFS_OUT,      32'hFFFF_FFFF);
    send_access(FUNC_READ,  OFS_IN,       '0);
    send_access(FUNC_WRITE, OFS_IN,       32'h0000_0000);
    send_access(FUNC_READ,  OFS_IN,       '0);
    send_access(FUNC_WRITE, OFS_SETRESET, 32'hFFFF_0000);
    // Both halves name every pin, so every pin must end up set.
    send_access(FUNC_WRITE, OFS_SETRESET, 32'hFFFF_FFFF);
    send_access(FUNC_READ,  OFS_SETRESET, '0);
    send_access(FUNC_WRITE, OFS_MODE,     32'hFFFF_FFFF);
    send_access(FUNC_WRITE, OFS_SETRESET, 32'hFFFF_0000);
    send_access(FUNC_WRITE, OFS_MODE,     32'h0000_0001);
    send_access(FUNC_WRITE, OFS_OUT,      32'h0000_0000);
    send_access(FUNC_READ,  OFS_OUT,      '0);
    send_access(FUNC_WRITE, OFS_TYPE,     32'hFFFF_FFFF);
    send_access(FUNC_WRITE, OFS_SPEED,    32'hA5A5_A5A5);
    send_access(FUNC_WRITE, OFS_PULL,     32'h5A5A_5A5A);
    send_access(FUNC_WRITE, OFS_LOCK,     32'hFFFF_FFFF);
    send_access(FUNC_WRITE, OFS_AFLO,     32'h1234_5678);
    send_access(FUNC_WRITE, OFS_AFHI,     32'hFFFF_FFFF);
    send_access(FUNC_READ,  OFS_TYPE,     '0);
    send_access(FUNC_READ,  OFS_LOCK,     '0);
    send_access(FUNC_READ,  OFS_AFHI,     '0);
    drain_results();

    // Random phases; the last one runs with no idling on either side.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_on = (ph == 0 || ph == 1);
      snk_idle_on = (ph == 0 || ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_access();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d reads, %0d writes and %0d unmapped accesses; %0d result beats checked.",
             sb.n_reads, sb.n_writes, sb.n_unmapped, sb.n_results);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gpb_pkg.sv
rtl/gpb_if.sv
rtl/gpb_in_stage.sv
rtl/gpb_regfile.sv
rtl/gpb_out_stage.sv
rtl/gpio_port_register_bank.sv
verif/gpio_port_register_bank_tb.sv
